>>> src/phone_number_table_match_assert.svh
// Assertion macros used by the checker file of the block.
`ifndef PHONE_NUMBER_TABLE_MATCH_ASSERT_SVH
`define PHONE_NUMBER_TABLE_MATCH_ASSERT_SVH

// Checked at every rising edge while reset is released.
`define PNTM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define PNTM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pntm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntm_pkg
// Types, sizes and helper functions of the phone number table.
// ----------------------------------------------------------------------------
package pntm_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int MAX_DIGITS  = 16;
	localparam int DIGITS_W    = 64;
	localparam int LEN_W       = 5;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KIND_W      = 2;
	localparam int OUT_IDX_W   = 6;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [LEN_W-1:0] MIN_SUFFIX_RESET = LEN_W'(6);

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE   = 2'd0,
		KIND_EXACT  = 2'd1,
		KIND_SUFFIX = 2'd2
	} match_kind_t;

	// Query item as it travels down the row of cells.
	typedef struct packed {
		logic                valid;
		logic [DIGITS_W-1:0] value;
		logic [LEN_W-1:0]    raw;
		logic                exact_en;
		logic                sfx_en;
		logic                exact_hit;
		logic [IDX_W-1:0]    exact_idx;
		logic                sfx_hit;
		logic [IDX_W-1:0]    sfx_idx;
	} pntm_tok_t;

	function automatic logic [LEN_W-1:0] clamp_count(input logic [LEN_W-1:0] n);
		clamp_count = (n > LEN_W'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS) : n;
	endfunction

	function automatic logic [DIGITS_W-1:0] digit_mask(input logic [LEN_W-1:0] n);
		logic [DIGITS_W-1:0] m;
		m = '0;
		for (int k = 0; k < DIGITS_W / 4; k++) begin
			if (LEN_W'(k) < n) begin
				m[4*k +: 4] = 4'hF;
			end
		end
		digit_mask = m;
	endfunction

	// The value is already masked to its count, so the highest nonzero
	// nibble sets the length; a zero value keeps one digit.
	function automatic logic [LEN_W-1:0] stripped_length(input logic [DIGITS_W-1:0] v);
		logic [LEN_W-1:0] len;
		len = LEN_W'(1);
		for (int k = 0; k < DIGITS_W / 4; k++) begin
			if (v[4*k +: 4] != 4'h0) begin
				len = LEN_W'(k + 1);
			end
		end
		stripped_length = len;
	endfunction

endpackage

>>> src/phone_number_table_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phone_number_table_match
// Phone number table with exact and trailing-digit lookup over a cell row.
// ----------------------------------------------------------------------------
// Port group  Direction  Handshake        Contents
// item in     in         start / busy     func, number_bcd, digit_count
// result      out        done (1 cycle)   match_kind, entry_index
// config      in         cfg_we           cfg_data (min_suffix_length)
//
// A load item writes the next free cell, if one is left; busy stays low.
// A query item walks the row of TABLE_DEPTH cells one cell per cycle, and its
// result strobes from the token register of the last cell; busy is high from
// acceptance until the result cycle, in which a new item may be taken.
// Reset clears the entry count, the cell valid bits and the query chain, and
// sets min_suffix_length to 6. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module phone_number_table_match
	import pntm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [DIGITS_W-1:0]  number_bcd,
	input  logic [LEN_W-1:0]     digit_count,
	input  logic                 cfg_we,
	input  logic [LEN_W-1:0]     cfg_data,
	output logic                 done,
	output logic [KIND_W-1:0]    match_kind,
	output logic [OUT_IDX_W-1:0] entry_index
);

	logic [LEN_W-1:0]    min_suffix_q;
	logic [CNT_W-1:0]    count_q;
	logic                busy_q;
	logic                accept;
	logic                load_go;
	logic                query_go;
	logic [LEN_W-1:0]    raw;
	logic [DIGITS_W-1:0] value;
	logic [LEN_W-1:0]    value_len;
	pntm_tok_t           issue_tok;
	pntm_tok_t           chain [TABLE_DEPTH+1];
	pntm_tok_t           last_tok;
	match_kind_t         kind;

	assign accept   = start && !busy;
	assign load_go  = accept && (func == FUNC_LOAD) && (count_q < CNT_W'(TABLE_DEPTH));
	assign query_go = accept && (func == FUNC_QUERY);

	assign raw       = clamp_count(digit_count);
	assign value     = number_bcd & digit_mask(raw);
	// A count of zero gives no digits at all, so the length stays zero.
	assign value_len = (raw == LEN_W'(0)) ? LEN_W'(0) : stripped_length(value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_suffix_q <= MIN_SUFFIX_RESET;
		end else if (cfg_we) begin
			min_suffix_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load_go) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (query_go) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_comb begin
		issue_tok           = '0;
		issue_tok.valid     = query_go;
		issue_tok.value     = value;
		issue_tok.raw       = raw;
		// A zero query is never looked up, so both compares stay off.
		issue_tok.exact_en  = (value != '0);
		issue_tok.sfx_en    = (value != '0) && (raw >= min_suffix_q);
	end

	assign chain[0] = issue_tok;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		pntm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr_en      (load_go && (count_q == CNT_W'(i))),
			.wr_digits  (value),
			.wr_length  (value_len),
			.cell_index (IDX_W'(i)),
			.tok_in     (chain[i]),
			.tok_out    (chain[i+1])
		);
	end

	assign last_tok = chain[TABLE_DEPTH];

	always_comb begin
		if (last_tok.exact_hit) begin
			kind        = KIND_EXACT;
			entry_index = OUT_IDX_W'(last_tok.exact_idx);
		end else if (last_tok.sfx_hit) begin
			kind        = KIND_SUFFIX;
			entry_index = OUT_IDX_W'(last_tok.sfx_idx);
		end else begin
			kind        = KIND_NONE;
			entry_index = '0;
		end
	end

	assign done       = last_tok.valid;
	assign match_kind = kind;
	assign busy       = busy_q && !done;

endmodule

>>> src/pntm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntm_cell
// One table entry with its compare logic and one stage of the query chain.
// ----------------------------------------------------------------------------
module pntm_cell
	import pntm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [DIGITS_W-1:0] wr_digits,
	input  logic [LEN_W-1:0]    wr_length,
	input  logic [IDX_W-1:0]    cell_index,
	input  pntm_tok_t           tok_in,
	output pntm_tok_t           tok_out
);

	logic                valid_q;
	logic [DIGITS_W-1:0] digits_q;
	logic [LEN_W-1:0]    length_q;
	pntm_tok_t           tok_q;
	pntm_tok_t           tok_d;
	logic                exact_eq;
	logic                sfx_eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			digits_q <= wr_digits;
			length_q <= wr_length;
		end
	end

	always_comb begin
		exact_eq = valid_q && tok_in.exact_en && (digits_q == tok_in.value);
		sfx_eq   = valid_q && tok_in.sfx_en && (tok_in.raw > length_q) &&
		           ((tok_in.value & digit_mask(length_q)) == digits_q);
		tok_d = tok_in;
		// The first hit along the chain is the lowest entry and is kept.
		if (!tok_in.exact_hit && exact_eq) begin
			tok_d.exact_hit = 1'b1;
			tok_d.exact_idx = cell_index;
		end
		if (!tok_in.sfx_hit && sfx_eq) begin
			tok_d.sfx_hit = 1'b1;
			tok_d.sfx_idx = cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> src/pntm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pntm_checker
// Port-level assertions of the phone number table, bound to the top level.
// ----------------------------------------------------------------------------
`include "phone_number_table_match_assert.svh"

module pntm_checker
	import pntm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 func,
	input logic                 done,
	input logic [KIND_W-1:0]    match_kind,
	input logic [OUT_IDX_W-1:0] entry_index
);

	`PNTM_ASSERT(a_kind_legal, clk, arst_n, done |-> (match_kind != 2'd3), "illegal match kind")
	`PNTM_ASSERT(a_none_zero_idx, clk, arst_n, (done && (match_kind == KIND_NONE)) |-> (entry_index == '0), "not found with nonzero index")
	`PNTM_ASSERT(a_load_no_result, clk, arst_n, (start && !busy && (func == FUNC_LOAD)) |=> !done, "load item produced a result")
	`PNTM_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> (!busy && !done), "busy or done during reset")

endmodule

bind phone_number_table_match pntm_checker u_pntm_checker (.*);
